>>> hdl/gnss_binary_frame_parser_unit_defines.svh
// Assertion helpers used by the drain block.
`ifndef GNSS_BINARY_FRAME_PARSER_UNIT_DEFINES_SVH
`define GNSS_BINARY_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GBFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbfp assertion failed");

// Next-cycle implication, disabled while in reset.
`define GBFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbfp assertion failed");

`endif

>>> hdl/gbfp_pkg.sv
`default_nettype none
package gbfp_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int RESULT_LIMIT     = 64;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] NAV_CLASS   = 8'h01;
  localparam logic [7:0] ID_POSITION = 8'h02;
  localparam logic [7:0] ID_VELOCITY = 8'h12;
  localparam logic [7:0] ID_STATUS   = 8'h03;

  localparam logic [6:0] MAX_PAYLOAD_RST = 7'd40;

  // Handoff from the frame parser to the readout once a frame has verified.
  typedef struct packed {
    logic       start;
    logic [7:0] id;
    logic [6:0] len;
    logic       pair;
  } drain_start_t;

endpackage
`default_nettype wire

>>> hdl/gbfp_ram.sv
`default_nettype none
module gbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/gbfp_parser.sv
`default_nettype none
module gbfp_parser
  import gbfp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_fire,
  input  wire logic [7:0]                      rx_byte,
  input  wire logic                            cfg_fire,
  input  wire logic [6:0]                      cfg_max_payload,
  output      logic                            wr_en,
  output      logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output      logic [7:0]                      wr_data,
  output      drain_start_t                    start
);

  localparam logic [3:0] ST_HUNT    = 4'd0;
  localparam logic [3:0] ST_SYNC2   = 4'd1;
  localparam logic [3:0] ST_CLASS   = 4'd2;
  localparam logic [3:0] ST_ID      = 4'd3;
  localparam logic [3:0] ST_LEN_LO  = 4'd4;
  localparam logic [3:0] ST_LEN_HI  = 4'd5;
  localparam logic [3:0] ST_PAYLOAD = 4'd6;
  localparam logic [3:0] ST_CK_A    = 4'd7;
  localparam logic [3:0] ST_CK_B    = 4'd8;

  localparam int         AW     = $clog2(BUFFER_DEPTH);
  localparam int         CapInt = (BUFFER_DEPTH < RESULT_LIMIT) ? BUFFER_DEPTH : RESULT_LIMIT;
  localparam logic [6:0] LimCap = 7'(CapInt);

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  frame_id_r, frame_id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic        pos_seen_r, pos_seen_nxt;
  logic        vel_seen_r, vel_seen_nxt;
  logic [6:0]  max_payload_r;
  logic [6:0]  limit;
  logic [15:0] len_full;
  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic        pos_mark;
  logic        vel_mark;
  logic        id_ok;

  assign limit    = (max_payload_r > LimCap) ? LimCap : max_payload_r;
  assign len_full = {rx_byte, len_lo_r};
  assign acc_a    = sum_a_r + rx_byte;
  assign acc_b    = sum_b_r + acc_a;
  assign id_ok    = (frame_id_r == ID_POSITION) || (frame_id_r == ID_VELOCITY) ||
                    (frame_id_r == ID_STATUS);
  assign pos_mark = pos_seen_r || (frame_id_r == ID_POSITION);
  assign vel_mark = vel_seen_r || (frame_id_r == ID_VELOCITY);

  assign wr_data = rx_byte;
  assign wr_addr = AW'(fill_r);

  always_comb begin
    state_nxt    = state_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    frame_id_nxt = frame_id_r;
    len_lo_nxt   = len_lo_r;
    len_nxt      = len_r;
    fill_nxt     = fill_r;
    pos_seen_nxt = pos_seen_r;
    vel_seen_nxt = vel_seen_r;
    wr_en        = 1'b0;
    start        = '0;
    start.id     = frame_id_r;
    start.len    = len_r;
    if (in_fire) begin
      case (state_r)
        ST_HUNT: begin
          if (rx_byte == SYNC_FIRST) begin
            state_nxt = ST_SYNC2;
          end
        end
        ST_SYNC2: begin
          state_nxt = (rx_byte == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
        end
        ST_CLASS: begin
          sum_a_nxt = rx_byte;
          sum_b_nxt = rx_byte;
          state_nxt = (rx_byte == NAV_CLASS) ? ST_ID : ST_HUNT;
        end
        ST_ID: begin
          sum_a_nxt    = acc_a;
          sum_b_nxt    = acc_b;
          frame_id_nxt = rx_byte;
          state_nxt    = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          sum_a_nxt  = acc_a;
          sum_b_nxt  = acc_b;
          len_lo_nxt = rx_byte;
          fill_nxt   = '0;
          state_nxt  = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
          fill_nxt  = '0;
          len_nxt   = len_full[6:0];
          // drop oversized frames right away
          if (len_full > {9'd0, limit}) begin
            state_nxt = ST_HUNT;
          end else if (len_full == 16'd0) begin
            state_nxt = ST_CK_A;
          end else begin
            state_nxt = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
          wr_en     = 1'b1;
          fill_nxt  = fill_r + 7'd1;
          if (fill_nxt >= len_r) begin
            state_nxt = ST_CK_A;
          end
        end
        ST_CK_A: begin
          state_nxt = (rx_byte == sum_a_r) ? ST_CK_B : ST_HUNT;
        end
        ST_CK_B: begin
          state_nxt = ST_HUNT;
          if ((rx_byte == sum_b_r) && (len_r != 7'd0) && id_ok) begin
            start.start = 1'b1;
            if (pos_mark && vel_mark) begin
              start.pair   = 1'b1;
              pos_seen_nxt = 1'b0;
              vel_seen_nxt = 1'b0;
            end else begin
              pos_seen_nxt = pos_mark;
              vel_seen_nxt = vel_mark;
            end
          end
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_HUNT;
      pos_seen_r    <= 1'b0;
      vel_seen_r    <= 1'b0;
      max_payload_r <= MAX_PAYLOAD_RST;
      fill_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      pos_seen_r <= pos_seen_nxt;
      vel_seen_r <= vel_seen_nxt;
      fill_r     <= fill_nxt;
      if (cfg_fire) begin
        max_payload_r <= cfg_max_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_a_r    <= sum_a_nxt;
    sum_b_r    <= sum_b_nxt;
    frame_id_r <= frame_id_nxt;
    len_lo_r   <= len_lo_nxt;
    len_r      <= len_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/gbfp_drain.sv
`default_nettype none
`include "gnss_binary_frame_parser_unit_defines.svh"
module gbfp_drain
  import gbfp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire drain_start_t                    start,
  output      logic                            busy,
  output      logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  input  wire logic [7:0]                      rd_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [7:0]                      out_message_id,
  output      logic [5:0]                      out_byte_index,
  output      logic [7:0]                      out_payload_byte,
  output      logic                            out_last,
  output      logic                            out_pair_ready
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic       active_r, active_nxt;
  logic [6:0] k_r, k_nxt;
  logic [6:0] len_r;
  logic [7:0] id_r;
  logic       pair_r;
  logic       pend_r;
  logic [5:0] pend_idx_r;
  logic       pend_last_r;
  logic       out_valid_r;
  logic [7:0] out_id_r;
  logic [5:0] out_idx_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_pair_r;
  logic       out_fire;
  logic       issue;
  logic       k_last;

  assign out_fire = out_valid_r && out_ready;
  // launch a read only when the output register is free by the time data lands
  assign issue    = active_r && !pend_r && (!out_valid_r || out_ready);
  assign k_last   = (k_r + 7'd1) == len_r;
  assign rd_addr  = AW'(k_r);
  assign busy     = active_r || pend_r;

  always_comb begin
    active_nxt = active_r;
    k_nxt      = k_r;
    if (start.start) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
    end else if (issue) begin
      k_nxt = k_r + 7'd1;
      if (k_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      active_r <= active_nxt;
      k_r      <= k_nxt;
      pend_r   <= issue;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.start) begin
      len_r  <= start.len;
      id_r   <= start.id;
      pair_r <= start.pair;
    end
    if (issue) begin
      pend_idx_r  <= k_r[5:0];
      pend_last_r <= k_last;
    end
    if (pend_r) begin
      out_id_r   <= id_r;
      out_idx_r  <= pend_idx_r;
      out_byte_r <= rd_data;
      out_last_r <= pend_last_r;
      out_pair_r <= pend_last_r && pair_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_message_id   = out_id_r;
  assign out_byte_index   = out_idx_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;
  assign out_pair_ready   = out_pair_r;

  `GBFP_ASSERT_NOW(a_land_into_empty, clk, rst_n, pend_r, !out_valid_r)
  `GBFP_ASSERT_NEXT(a_land_shows, clk, rst_n, pend_r, out_valid_r)
  `GBFP_ASSERT_NOW(a_no_start_busy, clk, rst_n, start.start, !busy)

endmodule
`default_nettype wire

>>> hdl/gnss_binary_frame_parser_unit.sv
// Binary GNSS frame parser: takes one serial byte per word on the in_ channel,
// hunts for B5 62, checks class 01, id, little-endian length and the 8-bit
// Fletcher checksum, and buffers the payload in a one-port-write, one-port-read
// RAM. Header and payload bytes are taken one per cycle while in_ready is high.
// After the second checksum byte of a verified position (02), velocity (12) or
// status (03) frame, the payload is read back from the RAM and delivered as one
// word per byte. A new RAM read is launched only after the previous one has
// landed in the output register and that register is empty or being taken;
// in_ready stays low while the readout is busy. out_last marks the final byte;
// out_pair_ready is set on it when the frame completes a position/velocity
// pair. Frames longer than min(cfg_max_payload, BUFFER_DEPTH, 64) are dropped.
// No clearing pass is needed after reset.
`default_nettype none
module gnss_binary_frame_parser_unit
  import gbfp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [6:0] cfg_max_payload,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_message_id,
  output      logic [5:0] out_byte_index,
  output      logic [7:0] out_payload_byte,
  output      logic       out_last,
  output      logic       out_pair_ready
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          busy;
  logic          in_fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  drain_start_t  start;

  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  gbfp_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .rx_byte        (in_rx_byte),
    .cfg_fire       (cfg_valid && cfg_ready),
    .cfg_max_payload(cfg_max_payload),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .start          (start)
  );

  gbfp_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  gbfp_drain #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_drain (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_message_id  (out_message_id),
    .out_byte_index  (out_byte_index),
    .out_payload_byte(out_payload_byte),
    .out_last        (out_last),
    .out_pair_ready  (out_pair_ready)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
  import gbfp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_SLACK = 200;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_BYTES = 8;

  typedef enum logic [3:0] {
    P_HUNT, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CK_A, P_CK_B
  } parse_phase_e;

  typedef enum logic [1:0] {F_ZERO, F_ONES, F_RAMP, F_RAND} fill_e;

  typedef struct packed {
    logic [7:0] id;
    logic [5:0] idx;
    logic [7:0] data;
    logic       is_last;
    logic       pair;
  } payload_word_t;

  typedef struct {
    logic [7:0]  sync2;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    fill_e       fill;
    logic        bad_a;
    logic        bad_b;
    logic        drop;
  } frame_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_max_payload;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_message_id;
  logic [5:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic       out_last;
  logic       out_pair_ready;

  gnss_binary_frame_parser_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_payload  (cfg_max_payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_id   (out_message_id),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .out_pair_ready   (out_pair_ready)
  );

  // Frame parser shadow state
  parse_phase_e pr_state;
  logic [6:0]   pr_max;
  logic [7:0]   pr_sum_a;
  logic [7:0]   pr_sum_b;
  logic [7:0]   pr_id;
  logic [7:0]   pr_len_lo;
  logic [15:0]  pr_len;
  logic [6:0]   pr_fill;
  logic [7:0]   pr_store [BUFFER_DEPTH_DEF];
  logic         pr_pos_seen;
  logic         pr_vel_seen;

  payload_word_t words_due[$];
  logic          suppress_words;
  int            mismatches;
  int unsigned   cycle_count;
  int            burst_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic int unsigned length_cap();
    int unsigned cap;
    cap = {25'd0, pr_max};
    if (cap > BUFFER_DEPTH_DEF) cap = BUFFER_DEPTH_DEF;
    if (cap > RESULT_LIMIT) cap = RESULT_LIMIT;
    return cap;
  endfunction

  task automatic fold_sum(input logic [7:0] b);
    pr_sum_a = pr_sum_a + b;
    pr_sum_b = pr_sum_b + pr_sum_a;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    payload_word_t w;
    logic          pair;
    int unsigned   n;
    case (pr_state)
      P_HUNT: begin
        if (b == SYNC_FIRST) pr_state = P_SYNC2;
      end
      P_SYNC2: pr_state = (b == SYNC_SECOND) ? P_CLASS : P_HUNT;
      P_CLASS: begin
        pr_sum_a = b;
        pr_sum_b = b;
        pr_state = (b == NAV_CLASS) ? P_ID : P_HUNT;
      end
      P_ID: begin
        fold_sum(b);
        pr_id = b;
        pr_state = P_LEN_LO;
      end
      P_LEN_LO: begin
        fold_sum(b);
        pr_len_lo = b;
        pr_fill = '0;
        pr_state = P_LEN_HI;
      end
      P_LEN_HI: begin
        fold_sum(b);
        pr_len = {b, pr_len_lo};
        pr_fill = '0;
        if (pr_len > length_cap()) pr_state = P_HUNT;
        else if (pr_len == 0) pr_state = P_CK_A;
        else pr_state = P_PAYLOAD;
      end
      P_PAYLOAD: begin
        fold_sum(b);
        if (pr_fill < BUFFER_DEPTH_DEF) pr_store[pr_fill[5:0]] = b;
        pr_fill = pr_fill + 7'd1;
        if (pr_fill >= pr_len) pr_state = P_CK_A;
      end
      P_CK_A: pr_state = (b == pr_sum_a) ? P_CK_B : P_HUNT;
      P_CK_B: begin
        pr_state = P_HUNT;
        if (b == pr_sum_b && pr_len > 0 && pr_len <= BUFFER_DEPTH_DEF &&
            pr_len <= RESULT_LIMIT &&
            (pr_id == ID_POSITION || pr_id == ID_VELOCITY || pr_id == ID_STATUS)) begin
          if (pr_id == ID_POSITION) pr_pos_seen = 1'b1;
          if (pr_id == ID_VELOCITY) pr_vel_seen = 1'b1;
          pair = pr_pos_seen && pr_vel_seen;
          if (pair) begin
            pr_pos_seen = 1'b0;
            pr_vel_seen = 1'b0;
          end
          n = {16'd0, pr_len};
          for (int unsigned k = 0; k < n; k++) begin
            w.id      = pr_id;
            w.idx     = k[5:0];
            w.data    = pr_store[k[5:0]];
            w.is_last = (k + 1 == n);
            w.pair    = (k + 1 == n) && pair;
            if (suppress_words)
              log_mismatch($sformatf("frame listed as dropped gives word idx %0d", k));
            else
              words_due.push_back(w);
          end
        end
      end
      default: pr_state = P_HUNT;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    predict_byte(b);
  endtask

  function automatic frame_row_t row(input logic [7:0] sync2, cls, id,
                                     input logic [15:0] len, input fill_e fill,
                                     input logic bad_a, bad_b, drop);
    frame_row_t r;
    r.sync2 = sync2;
    r.cls   = cls;
    r.id    = id;
    r.len   = len;
    r.fill  = fill;
    r.bad_a = bad_a;
    r.bad_b = bad_b;
    r.drop  = drop;
    return r;
  endfunction

  // Build the byte stream of one frame; stop where the parser gives up anyway.
  task automatic send_frame(input frame_row_t r, output int count);
    logic [7:0]  q[$];
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [7:0]  pb;
    int unsigned cap;
    cap = length_cap();
    ca = '0;
    cb = '0;
    q.push_back(SYNC_FIRST);
    q.push_back(r.sync2);
    if (r.sync2 == SYNC_SECOND) begin
      q.push_back(r.cls);
      if (r.cls == NAV_CLASS) begin
        q.push_back(r.id);
        q.push_back(r.len[7:0]);
        q.push_back(r.len[15:8]);
        if (r.len <= cap) begin
          for (int k = 0; k < r.len; k++) begin
            case (r.fill)
              F_ZERO:  pb = 8'h00;
              F_ONES:  pb = 8'hFF;
              F_RAMP:  pb = k[7:0];
              default: pb = 8'($urandom_range(0, 255));
            endcase
            q.push_back(pb);
          end
          for (int i = 2; i < q.size(); i++) begin
            ca = ca + q[i];
            cb = cb + ca;
          end
          q.push_back(ca ^ {7'd0, r.bad_a});
          if (!r.bad_a) q.push_back(cb ^ {7'd0, r.bad_b});
        end
      end
    end
    suppress_words = r.drop;
    foreach (q[i]) push_byte(q[i]);
    suppress_words = 1'b0;
    count = q.size();
  endtask

  task automatic send_random_frame(output int count);
    frame_row_t  r;
    int unsigned cap;
    int          roll;
    int          n;
    roll = $urandom_range(0, 99);
    count = 0;
    if (roll < 12) begin
      // line noise between frames
      repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
    end else if (roll < 17) begin
      push_byte(SYNC_FIRST);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      cap = length_cap();
      r = row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd1, F_RAND, 1'b0, 1'b0, 1'b0);
      if ($urandom_range(0, 19) == 0) r.cls = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 19);
      if (roll < 8) r.id = ID_POSITION;
      else if (roll < 14) r.id = ID_VELOCITY;
      else if (roll < 17) r.id = ID_STATUS;
      else r.id = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
        0:       r.len = 16'd0;
        1:       r.len = 16'(cap);
        2:       r.len = 16'(cap + 1);
        3:       r.len = 16'($urandom_range(0, 65535));
        4:       r.len = 16'($urandom_range(0, 70));
        default: r.len = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       r.fill = F_ZERO;
        1:       r.fill = F_ONES;
        default: r.fill = F_RAND;
      endcase
      r.bad_a = ($urandom_range(0, 14) == 0);
      r.bad_b = ($urandom_range(0, 14) == 0);
      send_frame(r, n);
      count = n;
    end
  endtask

  // Drain every expected word, then give the block time to finish a dropped frame.
  task automatic settle();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** gnss_binary_frame_parser_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    payload_word_t want;
    payload_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_message_id, out_byte_index, out_payload_byte, out_last, out_pair_ready};
      if (words_due.size() == 0) begin
        log_mismatch($sformatf("unexpected word: id %h idx %0d byte %h last %b pair %b",
                               got.id, got.idx, got.data, got.is_last, got.pair));
      end else begin
        want = words_due.pop_front();
        if (got !== want)
          log_mismatch($sformatf({"word mismatch: expected id %h idx %0d byte %h last %b ",
                                  "pair %b, got id %h idx %0d byte %h last %b pair %b"},
                                 want.id, want.idx, want.data, want.is_last, want.pair,
                                 got.id, got.idx, got.data, got.is_last, got.pair));
      end
    end
  end

  // Receiver: one long hold-off on the first word, then rotating stall masks.
  initial begin
    logic [15:0] stall_mask;
    int          tick;
    out_ready = 1'b0;
    stall_mask = 16'hFFFF;
    tick = 0;
    do @(posedge clk); while (!(rst_n && out_valid));
    for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
    forever begin
      if (tick % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hFFFF;
          1:       stall_mask = 16'($urandom_range(0, 65535));
          2:       stall_mask = 16'($urandom_range(0, 65535) | $urandom_range(0, 65535));
          default: stall_mask = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
        endcase
      end
      out_ready <= stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[15:1]};
      tick++;
      @(posedge clk);
    end
  end

  initial begin
    frame_row_t  plan[$];
    int unsigned cfg_plan[3];
    int          n;
    int          phase_bytes;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_byte      = 8'h00;
    cfg_valid       = 1'b0;
    cfg_max_payload = 7'd0;
    suppress_words  = 1'b0;
    mismatches      = 0;
    cycle_count     = 0;
    burst_left      = 0;
    pr_state    = P_HUNT;
    pr_max      = MAX_PAYLOAD_RST;
    pr_sum_a    = '0;
    pr_sum_b    = '0;
    pr_id       = '0;
    pr_len_lo   = '0;
    pr_len      = '0;
    pr_fill     = '0;
    pr_pos_seen = 1'b0;
    pr_vel_seen = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drop = 1 marks frames that must give no word at all
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd2, F_ONES,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd41, F_ZERO,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_FIRST, NAV_CLASS, ID_POSITION, 16'd1, F_ZERO,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, 8'h00, ID_POSITION, 16'd1, F_ZERO,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_VELOCITY, 16'd1, F_ZERO,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_STATUS, 16'd3, F_RAMP,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd0, F_ZERO,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd1, F_RAND,
                       1'b1, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_VELOCITY, 16'd1, F_RAND,
                       1'b0, 1'b1, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, 8'h05, 16'd1, F_RAND,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'h0100, F_ZERO,
                       1'b0, 1'b0, 1'b1));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_VELOCITY, 16'd1, F_RAND,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_STATUS, 16'd1, F_RAND,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd1, F_RAND,
                       1'b0, 1'b0, 1'b0));
    plan.push_back(row(SYNC_SECOND, NAV_CLASS, ID_POSITION, 16'd1, F_RAND,
                       1'b0, 1'b0, 1'b0));
    foreach (plan[i]) send_frame(plan[i], n);

    cfg_plan = '{64, 0, 8};
    cfg_plan[2] = $urandom_range(2, 16);
    foreach (cfg_plan[p]) begin
      settle();
      cfg_valid       <= 1'b1;
      cfg_max_payload <= cfg_plan[p][6:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      pr_max = cfg_plan[p][6:0];
      // open each setting with a frame at the length limit
      send_frame(row(SYNC_SECOND, NAV_CLASS, ID_STATUS, 16'(length_cap()), F_RAND,
                     1'b0, 1'b0, 1'b0), n);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_frame(n);
        phase_bytes += n;
      end
    end

    settle();
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("** gnss_binary_frame_parser_unit: PASSED **");
    end else begin
      $display("** gnss_binary_frame_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
